// ===== hdl/csb_pkg.sv =====
package csb_pkg;

	localparam int DEPTH      = 32;
	localparam int WORD_WIDTH = 64;

	// Count and cursor must hold DEPTH itself; cell indexes need only DEPTH - 1.
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	localparam int FUNC_W  = 3;
	localparam int VALUE_W = 64;
	localparam int COUNT_W = 6;

	typedef logic [WORD_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef enum logic [FUNC_W-1:0] {
		OP_QUERY   = 3'd0,
		OP_START   = 3'd1,
		OP_ADVANCE = 3'd2,
		OP_INSERT  = 3'd3,
		OP_ATTACH  = 3'd4,
		OP_REMOVE  = 3'd5
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
		logic err;
	} cmd_t;

	typedef struct packed {
		logic have;
		logic full;
	} status_t;

endpackage

// ===== hdl/csb_req_if.sv =====
interface csb_req_if;
	logic                         valid;
	logic                         ready;
	logic [csb_pkg::FUNC_W-1:0]   func;
	logic [csb_pkg::VALUE_W-1:0]  entry_value;

	modport source (output valid, output func, output entry_value, input ready);
	modport sink   (input valid, input func, input entry_value, output ready);
endinterface

// ===== hdl/csb_rsp_if.sv =====
interface csb_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [csb_pkg::VALUE_W-1:0]  current_value;
	logic                         has_item;
	logic [csb_pkg::COUNT_W-1:0]  item_count;
	logic                         op_error;

	modport source (output valid, output current_value, output has_item,
		output item_count, output op_error, input ready);
	modport sink   (input valid, input current_value, input has_item,
		input item_count, input op_error, output ready);
endinterface

// ===== hdl/cursor_sequence_buffer.sv =====
// Channel  Role    Payload
// req      sink    func, entry_value
// rsp      source  current_value, has_item, item_count, op_error
//
// Every request is applied in the cycle it is accepted; its response is valid the next cycle.
// One request per cycle while rsp.ready is high: the list is held in a chain of cell registers.
// arst_n clears the count, the cursor and the response valid; cells hold data only once written.
// A held response blocks req only while rsp.ready is low.
module cursor_sequence_buffer (
	input  logic       clk,
	input  logic       arst_n,
	csb_req_if.sink    req,
	csb_rsp_if.source  rsp
);

	csb_pkg::cmd_t    cmd;
	csb_pkg::status_t stat;

	csb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	csb_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.entry_value   (req.entry_value),
		.stat          (stat),
		.current_value (rsp.current_value),
		.has_item      (rsp.has_item),
		.item_count    (rsp.item_count),
		.op_error      (rsp.op_error)
	);

endmodule

// ===== hdl/csb_ctrl.sv =====
module csb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic [csb_pkg::FUNC_W-1:0]  req_func,
	output logic                        req_ready,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  csb_pkg::status_t            stat,
	output csb_pkg::cmd_t               cmd
);

	typedef enum logic {
		ST_EMPTY,
		ST_FULL
	} state_t;

	state_t state_q;
	logic   accept;

	// A new request may enter while the held response is taken in the same cycle.
	assign req_ready = (state_q == ST_EMPTY) || rsp_ready;
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd.load = accept;
		cmd.op   = csb_pkg::OP_QUERY;
		cmd.err  = 1'b0;
		unique case (req_func)
			csb_pkg::OP_START: begin
				cmd.op = csb_pkg::OP_START;
			end
			csb_pkg::OP_ADVANCE, csb_pkg::OP_REMOVE: begin
				if (stat.have) begin
					cmd.op = csb_pkg::op_t'(req_func);
				end else begin
					cmd.err = 1'b1;
				end
			end
			csb_pkg::OP_INSERT, csb_pkg::OP_ATTACH: begin
				if (!stat.full) begin
					cmd.op = csb_pkg::op_t'(req_func);
				end else begin
					cmd.err = 1'b1;
				end
			end
			default: begin
				cmd.op = csb_pkg::OP_QUERY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_EMPTY;
			rsp_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_EMPTY: begin
					if (accept) begin
						state_q   <= ST_FULL;
						rsp_valid <= 1'b1;
					end
				end
				ST_FULL: begin
					if (rsp_ready && !accept) begin
						state_q   <= ST_EMPTY;
						rsp_valid <= 1'b0;
					end
				end
				default: begin
					state_q   <= ST_EMPTY;
					rsp_valid <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hdl/csb_datapath.sv =====
module csb_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  csb_pkg::cmd_t                cmd,
	input  logic [csb_pkg::VALUE_W-1:0]  entry_value,
	output csb_pkg::status_t             stat,
	output logic [csb_pkg::VALUE_W-1:0]  current_value,
	output logic                         has_item,
	output logic [csb_pkg::COUNT_W-1:0]  item_count,
	output logic                         op_error
);

	csb_pkg::word_t cells_q [csb_pkg::DEPTH];
	csb_pkg::cnt_t  count_q;
	csb_pkg::cnt_t  cursor_q;

	csb_pkg::word_t wval;
	csb_pkg::cnt_t  cursor_inc;
	csb_pkg::cnt_t  pos;
	csb_pkg::cnt_t  cursor_d;
	csb_pkg::cnt_t  count_d;
	csb_pkg::cnt_t  raddr;
	csb_pkg::word_t rdata;
	csb_pkg::word_t value_d;
	logic           has_d;
	logic           grow;
	logic           shrink;

	csb_pkg::word_t res_value_q;
	logic           res_has_q;
	csb_pkg::cnt_t  res_count_q;
	logic           res_err_q;

	assign wval       = entry_value[csb_pkg::WORD_WIDTH-1:0];
	assign stat.have  = cursor_q < count_q;
	assign stat.full  = count_q == csb_pkg::CNT_W'(csb_pkg::DEPTH);
	assign cursor_inc = cursor_q + csb_pkg::CNT_W'(1);
	assign grow       = cmd.load && (cmd.op == csb_pkg::OP_INSERT || cmd.op == csb_pkg::OP_ATTACH);
	assign shrink     = cmd.load && (cmd.op == csb_pkg::OP_REMOVE);

	// Slot that receives a new word: insert goes before the current entry
	// (or to the front), attach goes after it (or to the end).
	always_comb begin
		if (cmd.op == csb_pkg::OP_INSERT) begin
			pos = stat.have ? cursor_q : '0;
		end else begin
			pos = stat.have ? cursor_inc : count_q;
		end
	end

	always_comb begin
		cursor_d = cursor_q;
		count_d  = count_q;
		raddr    = cursor_q;
		unique case (cmd.op)
			csb_pkg::OP_START: begin
				cursor_d = '0;
				raddr    = '0;
			end
			csb_pkg::OP_ADVANCE: begin
				cursor_d = cursor_inc;
				raddr    = cursor_inc;
			end
			csb_pkg::OP_INSERT, csb_pkg::OP_ATTACH: begin
				cursor_d = pos;
				count_d  = count_q + csb_pkg::CNT_W'(1);
			end
			csb_pkg::OP_REMOVE: begin
				// The follower slides into the cursor slot, so read it before the shift.
				count_d = count_q - csb_pkg::CNT_W'(1);
				raddr   = cursor_inc;
			end
			default: begin
				cursor_d = cursor_q;
			end
		endcase
	end

	always_comb begin
		if (raddr < csb_pkg::CNT_W'(csb_pkg::DEPTH)) begin
			rdata = cells_q[raddr[csb_pkg::IDX_W-1:0]];
		end else begin
			rdata = '0;
		end
		has_d = cursor_d < count_d;
		if (!has_d) begin
			value_d = '0;
		end else if (grow) begin
			value_d = wval;
		end else begin
			value_d = rdata;
		end
	end

	// Cells above pos shift up on a grow, cells from the cursor down on a remove.
	for (genvar i = 0; i < csb_pkg::DEPTH; i++) begin : g_cell
		localparam csb_pkg::cnt_t IDX = csb_pkg::CNT_W'(i);
		always_ff @(posedge clk) begin
			if (grow) begin
				if (IDX == pos) begin
					cells_q[i] <= wval;
				end else if (i > 0 && IDX > pos && IDX <= count_q) begin
					cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
				end
			end else if (shrink) begin
				if (i < csb_pkg::DEPTH - 1 && IDX >= cursor_q
						&& IDX + csb_pkg::CNT_W'(1) < count_q) begin
					cells_q[i] <= cells_q[(i < csb_pkg::DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
		end else if (cmd.load) begin
			count_q  <= count_d;
			cursor_q <= cursor_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_value_q <= value_d;
			res_has_q   <= has_d;
			res_count_q <= count_d;
			res_err_q   <= cmd.err;
		end
	end

	assign current_value = csb_pkg::VALUE_W'(res_value_q);
	assign has_item      = res_has_q;
	assign item_count    = csb_pkg::COUNT_W'(res_count_q);
	assign op_error      = res_err_q;

endmodule

// ===== tb/csb_list_checker.sv =====
`timescale 1ns / 1ps

module csb_list_checker
	import csb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	csb_req_if          req,
	csb_rsp_if          rsp,
	output int unsigned mismatches,
	output int unsigned awaiting
);

	typedef struct {
		word_t              value;
		logic               has;
		logic [COUNT_W-1:0] cnt;
		logic               err;
	} list_view_t;

	word_t        shadow_words [DEPTH];
	int unsigned  used;
	int unsigned  pos;
	list_view_t   expected_views [$];

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
		mismatches++;
	endtask

	// Applies one request to the shadow list and returns what the block should report.
	function automatic list_view_t apply_list_op(input logic [FUNC_W-1:0] f,
			input logic [VALUE_W-1:0] v);
		list_view_t  view;
		logic        have;
		logic        full;
		int unsigned i;
		have     = pos < used;
		full     = used >= DEPTH;
		view.err = 1'b0;
		case (f)
			OP_START: begin
				pos = 0;
			end
			OP_ADVANCE: begin
				if (!have) view.err = 1'b1;
				else pos++;
			end
			OP_INSERT: begin
				if (full) begin
					view.err = 1'b1;
				end else begin
					if (!have) pos = 0;
					for (i = used; i > pos; i--) shadow_words[i] = shadow_words[i-1];
					shadow_words[pos] = v[WORD_WIDTH-1:0];
					used++;
				end
			end
			OP_ATTACH: begin
				if (full) begin
					view.err = 1'b1;
				end else if (!have) begin
					shadow_words[used] = v[WORD_WIDTH-1:0];
					pos = used;
					used++;
				end else begin
					for (i = used; i > pos + 1; i--) shadow_words[i] = shadow_words[i-1];
					shadow_words[pos+1] = v[WORD_WIDTH-1:0];
					pos++;
					used++;
				end
			end
			OP_REMOVE: begin
				if (!have) begin
					view.err = 1'b1;
				end else begin
					for (i = pos + 1; i < used; i++) shadow_words[i-1] = shadow_words[i];
					used--;
				end
			end
			default: begin
			end
		endcase
		view.has   = pos < used;
		view.value = view.has ? shadow_words[pos] : '0;
		view.cnt   = used[COUNT_W-1:0];
		return view;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_view_t want;
		if (!arst_n) begin
			used = 0;
			pos  = 0;
			expected_views.delete();
			mismatches = 0;
			awaiting   = 0;
		end else begin
			// A response accepted at this edge belongs to an earlier request, so match first.
			if (rsp.valid && rsp.ready) begin
				if (expected_views.size() == 0) begin
					report_mismatch("unexpected response, item_count",
						64'(rsp.item_count), '0);
				end else begin
					want = expected_views.pop_front();
					if (rsp.current_value !== want.value)
						report_mismatch("current_value", rsp.current_value, want.value);
					if (rsp.has_item !== want.has)
						report_mismatch("has_item", 64'(rsp.has_item), 64'(want.has));
					if (rsp.item_count !== want.cnt)
						report_mismatch("item_count", 64'(rsp.item_count), 64'(want.cnt));
					if (rsp.op_error !== want.err)
						report_mismatch("op_error", 64'(rsp.op_error), 64'(want.err));
				end
			end
			if (req.valid && req.ready)
				expected_views.push_back(apply_list_op(req.func, req.entry_value));
			awaiting = expected_views.size();
		end
	end

endmodule

// ===== tb/tb_cursor_sequence_buffer.sv =====
`timescale 1ns / 1ps

module tb_cursor_sequence_buffer;
	import csb_pkg::*;

	localparam int TOTAL_ITEMS = 1650;
	localparam int QUIET_TAIL  = 200;

	localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

	localparam int MIX_GROW   = 0;
	localparam int MIX_SHRINK = 1;
	localparam int MIX_EVEN   = 2;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          gaps_on;
	bit          stalls_on;
	int          sent;
	int unsigned mismatches;
	int unsigned awaiting;

	csb_req_if req ();
	csb_rsp_if rsp ();

	cursor_sequence_buffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	csb_list_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_req(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		req.valid       <= 1'b1;
		req.func        <= f;
		req.entry_value <= v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic [FUNC_W-1:0] pick_func(input int mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_GROW: begin
				if (r < 35) return OP_INSERT;
				if (r < 70) return OP_ATTACH;
				if (r < 80) return OP_ADVANCE;
				if (r < 87) return OP_START;
				if (r < 93) return OP_REMOVE;
				if (r < 97) return OP_QUERY;
			end
			MIX_SHRINK: begin
				if (r < 45) return OP_REMOVE;
				if (r < 65) return OP_ADVANCE;
				if (r < 80) return OP_START;
				if (r < 88) return OP_INSERT;
				if (r < 95) return OP_ATTACH;
				if (r < 98) return OP_QUERY;
			end
			default: begin
				if (r < 18) return OP_INSERT;
				if (r < 36) return OP_ATTACH;
				if (r < 54) return OP_REMOVE;
				if (r < 72) return OP_ADVANCE;
				if (r < 84) return OP_START;
				if (r < 94) return OP_QUERY;
			end
		endcase
		return r[0] ? FUNC_SPARE_HI : FUNC_SPARE_LO;
	endfunction

	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stalls_on && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	initial begin
		int  mix;
		int  len;
		bit  quiet;
		bit  drained;
		req.valid       = 1'b0;
		req.func        = OP_QUERY;
		req.entry_value = '0;
		gaps_on         = 1'b0;
		stalls_on       = 1'b0;
		sent            = 0;
		drained         = 1'b0;
		arst_n          = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty list: the advance and remove errors and the spare selectors.
		send_req(OP_QUERY, '0);
		send_req(OP_ADVANCE, '1);
		send_req(OP_REMOVE, '0);
		send_req(OP_START, '1);
		send_req(FUNC_SPARE_LO, '1);
		send_req(FUNC_SPARE_HI, '0);
		// Build a short list, then walk the cursor off its end.
		send_req(OP_INSERT, '1);
		send_req(OP_ATTACH, '0);
		send_req(OP_INSERT, 64'h5555_5555_5555_5555);
		send_req(OP_START, '0);
		send_req(OP_ADVANCE, '0);
		send_req(OP_ADVANCE, '0);
		send_req(OP_ADVANCE, '0);
		send_req(OP_ADVANCE, '0);
		send_req(OP_REMOVE, '0);
		send_req(OP_ATTACH, 64'hAAAA_AAAA_AAAA_AAAA);
		send_req(OP_INSERT, 64'h8000_0000_0000_0001);
		send_req(OP_START, '0);
		send_req(OP_REMOVE, '0);
		send_req(OP_REMOVE, '0);
		send_req(OP_QUERY, '0);

		// Growth-heavy runs push the list toward full, shrink-heavy runs drain it toward empty.
		while (sent < TOTAL_ITEMS) begin
			mix       = $urandom_range(MIX_GROW, MIX_EVEN);
			len       = $urandom_range(30, 80);
			quiet     = sent >= TOTAL_ITEMS - QUIET_TAIL;
			gaps_on   = !quiet && $urandom_range(0, 3) != 0;
			stalls_on = !quiet && $urandom_range(0, 3) != 0;
			for (int k = 0; k < len && sent < TOTAL_ITEMS; k++)
				send_req(pick_func(mix), {$urandom, $urandom});
			if (!drained && sent >= TOTAL_ITEMS / 2) begin
				drained = 1'b1;
				req.valid <= 1'b0;
				wait (awaiting == 0);
				@(negedge clk);
			end
		end
		req.valid <= 1'b0;

		wait (awaiting == 0);
		repeat (5) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
